@@ rtl/pngunf_pkg.sv @@
// ----------------------------------------------------------------------------
// PNG unfilter package
// Shared constants, command codes, job and configuration types, and helpers.
// ----------------------------------------------------------------------------
package pngunf_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int ROW_STORE_BYTES = MAX_WIDTH * 4;
   localparam int STORE_AW        = $clog2(ROW_STORE_BYTES);
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_PALETTE = 2'd1;
   localparam logic [1:0] CMD_BYTE    = 2'd2;

   localparam logic [2:0] FLT_NONE  = 3'd0;
   localparam logic [2:0] FLT_SUB   = 3'd1;
   localparam logic [2:0] FLT_UP    = 3'd2;
   localparam logic [2:0] FLT_AVG   = 3'd3;
   localparam logic [2:0] FLT_PAETH = 3'd4;

   localparam logic [2:0] CT_GRAY = 3'd0;
   localparam logic [2:0] CT_RGB  = 3'd2;
   localparam logic [2:0] CT_PAL  = 3'd3;
   localparam logic [2:0] CT_GA   = 3'd4;
   localparam logic [2:0] CT_RGBA = 3'd6;

   localparam logic [1:0] CSR_COLOR_TYPE  = 2'd0;
   localparam logic [1:0] CSR_BIT_DEPTH   = 2'd1;
   localparam logic [1:0] CSR_IMAGE_WIDTH = 2'd2;

   localparam logic [31:0] OPAQUE_BLACK = 32'hFF000000;

   typedef struct packed {
      logic [2:0]  ct;
      logic [3:0]  depth;
      logic [2:0]  ch;
      logic [12:0] width;
   } cfg_type;

   typedef struct packed {
      logic        is_pal_wr;
      logic        use_pal;
      logic        low_depth;
      logic [3:0]  depth;
      logic [7:0]  idx;
      logic [31:0] argb;
      logic [11:0] col;
      logic [3:0]  count;
      logic        row_end;
   } job_type;

   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [10:0] p;
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
      da = p - $signed({3'b000, a});
      db = p - $signed({3'b000, b});
      dc = p - $signed({3'b000, c});
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      return (db <= dc) ? b : c;
   endfunction

   function automatic logic [7:0] expand_gray(input logic [7:0] v, input logic [3:0] depth);
      logic [7:0] g;
      case (depth)
         4'd1:    g = v[0] ? 8'hFF : 8'h00;
         4'd2:    g = {v[1:0], v[1:0], v[1:0], v[1:0]};
         4'd4:    g = {v[3:0], v[3:0]};
         default: g = v;
      endcase
      return g;
   endfunction

endpackage

@@ rtl/pngunf_front.sv @@
// ----------------------------------------------------------------------------
// PNG unfilter front end
// Accepts commands, reconstructs filtered bytes against the line store and
// turns them into pixel jobs, and palette loads into palette writes, for the back end.
// ----------------------------------------------------------------------------
module pngunf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_fire,
   input  logic [1:0]          in_cmd,
   input  logic [7:0]          in_byte,
   input  logic [7:0]          in_index,
   input  logic [7:0]          in_red,
   input  logic [7:0]          in_green,
   input  logic [7:0]          in_blue,
   input  logic [7:0]          in_alpha,
   input  pngunf_pkg::cfg_type cfg,
   output logic                push,
   output pngunf_pkg::job_type job
);

   logic [14:0] pos_ff, pos_in;
   logic [2:0]  filt_ff, filt_in;
   logic        first_ff, first_in;
   logic [7:0]  left_ff [4];
   logic [7:0]  left_in [4];
   logic [7:0]  uleft_ff [4];
   logic [7:0]  uleft_in [4];
   logic [23:0] part_ff, part_in;
   logic [12:0] col_ff, col_in;
   logic [1:0]  m3_ff, m3_in;
   logic [7:0]  rd_ff;

   logic [7:0]  store_mem [pngunf_pkg::ROW_STORE_BYTES];

   logic [14:0] i_pos;
   logic        in_store;
   logic [1:0]  bpp_m1;
   logic [7:0]  a_v, b_v, c_v, x_rec;
   logic        depth8;
   logic [1:0]  kmod;
   logic        grp_done;
   logic [12:0] remain;
   logic [3:0]  per;
   logic [3:0]  n_pix;
   logic [5:0]  cd;
   logic [18:0] row_bits;
   logic [15:0] row_bytes;
   logic        row_end;
   logic [31:0] direct;
   logic        is_data;
   logic        store_we;
   logic [14:0] rd_pos;

   always_comb begin
      i_pos    = pos_ff - 15'd1;
      in_store = 32'(i_pos) < pngunf_pkg::ROW_STORE_BYTES;
      depth8   = cfg.depth == 4'd8;
      bpp_m1   = depth8 ? 2'(cfg.ch - 3'd1) : 2'd0;
      a_v      = left_ff[bpp_m1];
      c_v      = first_ff ? 8'd0 : uleft_ff[bpp_m1];
      b_v      = (!first_ff && in_store) ? rd_ff : 8'd0;
      case (filt_ff)
         pngunf_pkg::FLT_SUB:   x_rec = in_byte + a_v;
         pngunf_pkg::FLT_UP:    x_rec = in_byte + b_v;
         pngunf_pkg::FLT_AVG:   x_rec = in_byte + 8'((9'(a_v) + 9'(b_v)) >> 1);
         pngunf_pkg::FLT_PAETH: x_rec = in_byte + pngunf_pkg::paeth_pick(a_v, b_v, c_v);
         default:               x_rec = in_byte;
      endcase
      case (cfg.ch)
         3'd2:    kmod = {1'b0, i_pos[0]};
         3'd3:    kmod = m3_ff;
         3'd4:    kmod = i_pos[1:0];
         default: kmod = 2'd0;
      endcase
      grp_done = kmod == 2'(cfg.ch - 3'd1);
      remain   = cfg.width - col_ff;
      case (cfg.depth)
         4'd1:    per = 4'd8;
         4'd2:    per = 4'd4;
         default: per = 4'd2;
      endcase
      if (col_ff >= cfg.width) begin
         n_pix = 4'd0;
      end else if (depth8) begin
         n_pix = grp_done ? 4'd1 : 4'd0;
      end else begin
         n_pix = (remain < 13'(per)) ? 4'(remain) : per;
      end
      cd        = 6'(cfg.ch) * 6'(cfg.depth);
      row_bits  = 19'(cfg.width) * 19'(cd);
      row_bytes = 16'((row_bits + 19'd7) >> 3);
      row_end   = (16'(i_pos) + 16'd1) >= row_bytes;
      case (cfg.ct)
         pngunf_pkg::CT_RGB:  direct = pngunf_pkg::OPAQUE_BLACK | {8'd0, part_ff[15:0], x_rec};
         pngunf_pkg::CT_RGBA: direct = {x_rec, part_ff};
         pngunf_pkg::CT_GA:   direct = {x_rec, part_ff[7:0], part_ff[7:0], part_ff[7:0]};
         default:             direct = pngunf_pkg::OPAQUE_BLACK | {8'd0, x_rec, x_rec, x_rec};
      endcase
      is_data  = in_fire && in_cmd == pngunf_pkg::CMD_BYTE && pos_ff != 15'd0;
      store_we = is_data && in_store;
   end

   always_comb begin
      pos_in   = pos_ff;
      filt_in  = filt_ff;
      first_in = first_ff;
      left_in  = left_ff;
      uleft_in = uleft_ff;
      part_in  = part_ff;
      col_in   = col_ff;
      m3_in    = m3_ff;
      if (in_fire) begin
         case (in_cmd)
            pngunf_pkg::CMD_START: begin
               pos_in   = 15'd0;
               first_in = 1'b1;
               left_in  = '{default: 8'd0};
               uleft_in = '{default: 8'd0};
               part_in  = 24'd0;
               col_in   = 13'd0;
               m3_in    = 2'd0;
            end
            pngunf_pkg::CMD_BYTE: begin
               if (pos_ff == 15'd0) begin
                  filt_in  = (in_byte <= 8'd4) ? in_byte[2:0] : pngunf_pkg::FLT_NONE;
                  pos_in   = 15'd1;
                  left_in  = '{default: 8'd0};
                  uleft_in = '{default: 8'd0};
                  part_in  = 24'd0;
                  col_in   = 13'd0;
                  m3_in    = 2'd0;
               end else begin
                  left_in  = '{x_rec, left_ff[0], left_ff[1], left_ff[2]};
                  uleft_in = '{b_v, uleft_ff[0], uleft_ff[1], uleft_ff[2]};
                  if (depth8) begin
                     part_in = grp_done ? 24'd0 : {part_ff[15:0], x_rec};
                  end
                  col_in = col_ff + 13'(n_pix);
                  m3_in  = (m3_ff == 2'd2) ? 2'd0 : m3_ff + 2'd1;
                  if (row_end) begin
                     pos_in   = 15'd0;
                     first_in = 1'b0;
                     left_in  = '{default: 8'd0};
                     uleft_in = '{default: 8'd0};
                     part_in  = 24'd0;
                     col_in   = 13'd0;
                     m3_in    = 2'd0;
                  end else begin
                     pos_in = pos_ff + 15'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 15'd0;
         filt_ff  <= pngunf_pkg::FLT_NONE;
         first_ff <= 1'b1;
         left_ff  <= '{default: 8'd0};
         uleft_ff <= '{default: 8'd0};
         part_ff  <= 24'd0;
         col_ff   <= 13'd0;
         m3_ff    <= 2'd0;
      end else begin
         pos_ff   <= pos_in;
         filt_ff  <= filt_in;
         first_ff <= first_in;
         left_ff  <= left_in;
         uleft_ff <= uleft_in;
         part_ff  <= part_in;
         col_ff   <= col_in;
         m3_ff    <= m3_in;
      end
   end

   // The store is read one position ahead, so the byte above is ready on arrival.
   assign rd_pos = pos_in - 15'd1;

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[i_pos[pngunf_pkg::STORE_AW-1:0]] <= x_rec;
      end
      rd_ff <= store_mem[rd_pos[pngunf_pkg::STORE_AW-1:0]];
   end

   always_comb begin
      push = (in_fire && in_cmd == pngunf_pkg::CMD_PALETTE &&
              32'(in_index) < pngunf_pkg::PALETTE_ENTRIES) ||
             (is_data && n_pix != 4'd0);
      job.is_pal_wr = in_cmd == pngunf_pkg::CMD_PALETTE;
      job.use_pal   = cfg.ct == pngunf_pkg::CT_PAL;
      job.low_depth = !depth8;
      job.depth     = cfg.depth;
      job.idx       = job.is_pal_wr ? in_index : x_rec;
      job.argb      = job.is_pal_wr ? {in_alpha, in_red, in_green, in_blue} : direct;
      job.col       = col_ff[11:0];
      job.count     = n_pix;
      job.row_end   = (col_ff + 13'(n_pix)) == cfg.width;
   end

   assert property (@(posedge clock) disable iff (reset)
      in_fire && in_cmd == pngunf_pkg::CMD_BYTE && pos_ff == 15'd0 |=> pos_ff == 15'd1)
      else $error("filter byte did not open the row");
   assert property (@(posedge clock) disable iff (reset)
      push && !job.is_pal_wr |-> job.count <= 4'd8 && col_ff < cfg.width)
      else $error("pixel job beyond the row or too long");

endmodule

@@ rtl/pngunf_queue.sv @@
// ----------------------------------------------------------------------------
// PNG unfilter job queue
// Short first-in first-out queue of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module pngunf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pngunf_pkg::job_type push_job,
   input  logic                pop,
   output pngunf_pkg::job_type head,
   output logic                not_empty,
   output logic                full
);

   localparam int CW = $clog2(pngunf_pkg::QUEUE_DEPTH + 1);

   pngunf_pkg::job_type slot_ff [pngunf_pkg::QUEUE_DEPTH];
   logic [pngunf_pkg::QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      not_empty = cnt_ff != CW'(0);
      full      = cnt_ff == CW'(pngunf_pkg::QUEUE_DEPTH);
      head      = slot_ff[rd_ff];
      wr_in     = push ? wr_ff + 1'b1 : wr_ff;
      rd_in     = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in    = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("pop from an empty queue");

endmodule

@@ rtl/pngunf_back.sv @@
// ----------------------------------------------------------------------------
// PNG unfilter back end
// Steps through each job one pixel a cycle while the output is not stalled,
// holds the palette and drives the registered pixel output.
// ----------------------------------------------------------------------------
module pngunf_back (
   input  logic                clock,
   input  logic                reset,
   input  pngunf_pkg::job_type head,
   input  logic                head_valid,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [31:0]         out_argb,
   output logic [11:0]         out_col,
   output logic                out_row_done,
   output logic                out_last
);

   logic [31:0] pal_mem [pngunf_pkg::PALETTE_ENTRIES];
   logic [pngunf_pkg::PALETTE_ENTRIES-1:0] pal_vld_ff;

   logic [2:0]  s_ff;
   logic        ov_ff;
   logic [11:0] col_ff;
   logic        rdone_ff;
   logic        last_ff;
   logic        usepal_ff;
   logic [31:0] direct_ff;
   logic [31:0] prd_ff;
   logic        pvld_ff;

   logic        adv;
   logic        last_step;
   logic [7:0]  prod;
   logic [3:0]  shamt;
   logic [7:0]  mask;
   logic [7:0]  v;
   logic [7:0]  gray;
   logic [31:0] direct;
   logic        pal_ok;

   always_comb begin
      adv       = head_valid && (!ov_ff || out_ready);
      last_step = ({1'b0, s_ff} + 4'd1) == head.count;
      pop       = adv && (head.is_pal_wr || last_step);
      prod      = 8'(head.depth) * (8'(s_ff) + 8'd1);
      shamt     = 4'(8'd8 - prod);
      mask      = 8'((9'd1 << head.depth) - 9'd1);
      v         = (head.idx >> shamt) & mask;
      gray      = pngunf_pkg::expand_gray(v, head.depth);
      direct    = head.low_depth ? (pngunf_pkg::OPAQUE_BLACK | {8'd0, gray, gray, gray})
                                 : head.argb;
      pal_ok    = 32'(v) < pngunf_pkg::PALETTE_ENTRIES;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff      <= 1'b0;
         s_ff       <= 3'd0;
         pal_vld_ff <= '0;
      end else if (adv) begin
         if (head.is_pal_wr) begin
            ov_ff <= 1'b0;
            pal_vld_ff[head.idx[pngunf_pkg::PAL_AW-1:0]] <= 1'b1;
         end else begin
            ov_ff <= 1'b1;
            s_ff  <= last_step ? 3'd0 : s_ff + 3'd1;
         end
      end else if (out_ready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && head.is_pal_wr) begin
         pal_mem[head.idx[pngunf_pkg::PAL_AW-1:0]] <= head.argb;
      end
      if (adv && !head.is_pal_wr) begin
         prd_ff    <= pal_mem[v[pngunf_pkg::PAL_AW-1:0]];
         pvld_ff   <= pal_ok && pal_vld_ff[v[pngunf_pkg::PAL_AW-1:0]];
         col_ff    <= head.col + 12'(s_ff);
         rdone_ff  <= head.row_end && last_step;
         last_ff   <= last_step;
         usepal_ff <= head.use_pal;
         direct_ff <= direct;
      end
   end

   always_comb begin
      out_valid    = ov_ff;
      out_argb     = usepal_ff ? (pvld_ff ? prd_ff : pngunf_pkg::OPAQUE_BLACK) : direct_ff;
      out_col      = col_ff;
      out_row_done = rdone_ff;
      out_last     = last_ff;
   end

   assert property (@(posedge clock) disable iff (reset) ov_ff && rdone_ff |-> last_ff)
      else $error("row end pixel is not the last of its byte");
   assert property (@(posedge clock) disable iff (reset) s_ff != 3'd0 |-> head_valid)
      else $error("pixel step under way with no job");

endmodule

@@ rtl/png_scanline_unfilter_to_argb.sv @@
// ----------------------------------------------------------------------------
// PNG scanline unfilter to ARGB8888
// Reconstructs filtered PNG rows and unpacks them into ARGB8888 pixels.
// ----------------------------------------------------------------------------
// The block takes one command or scanline byte per cycle while the job queue
// has room, and gives one pixel per cycle while the output is not stalled. A
// byte is reconstructed in the cycle of its transfer against a 16384 by 8 line
// store, which is never cleared; a four-entry job queue then parts it from the
// pixel stepper, which takes one step for each pixel that a byte yields (at most
// one at 8 bits per sample, up to eight at 1 bit) and one for each palette load.
// Sustained input is therefore one byte per cycle at 8-bit depth; at lower depths
// it is bound by the stepper, while the output side keeps taking pixels.
module png_scanline_unfilter_to_argb (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // data_byte, entry_index, red, green, blue, alpha
   input  logic [1:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // pixel_argb, pixel_column, zero fill
   output logic [0:0]  rsp_tuser,  // row_done
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   logic [2:0]  ct_ff;
   logic [3:0]  bd_ff;
   logic [12:0] w_ff;

   pngunf_pkg::cfg_type cfg;
   pngunf_pkg::job_type push_job;
   pngunf_pkg::job_type head;
   logic        push, pop, not_empty, full, in_fire;
   logic [31:0] out_argb;
   logic [11:0] out_col;
   logic        out_row_done;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ct_ff <= pngunf_pkg::CT_RGBA;
         bd_ff <= 4'd8;
         w_ff  <= 13'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pngunf_pkg::CSR_COLOR_TYPE:  ct_ff <= csr_data[2:0];
            pngunf_pkg::CSR_BIT_DEPTH:   bd_ff <= csr_data[3:0];
            pngunf_pkg::CSR_IMAGE_WIDTH: w_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.ct = ct_ff;
      if (ct_ff inside {pngunf_pkg::CT_RGB, pngunf_pkg::CT_GA, pngunf_pkg::CT_RGBA}) begin
         cfg.depth = 4'd8;
      end else if (bd_ff inside {4'd1, 4'd2, 4'd4}) begin
         cfg.depth = bd_ff;
      end else begin
         cfg.depth = 4'd8;
      end
      case (ct_ff)
         pngunf_pkg::CT_RGB:  cfg.ch = 3'd3;
         pngunf_pkg::CT_RGBA: cfg.ch = 3'd4;
         pngunf_pkg::CT_GA:   cfg.ch = 3'd2;
         default:             cfg.ch = 3'd1;
      endcase
      if (w_ff == 13'd0) begin
         cfg.width = 13'd1;
      end else if (32'(w_ff) > pngunf_pkg::MAX_WIDTH) begin
         cfg.width = 13'(pngunf_pkg::MAX_WIDTH);
      end else begin
         cfg.width = w_ff;
      end
   end

   assign req_tready = !full;
   assign in_fire    = req_tvalid && req_tready;

   pngunf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .in_cmd   (req_tuser),
      .in_byte  (req_tdata[7:0]),
      .in_index (req_tdata[15:8]),
      .in_red   (req_tdata[23:16]),
      .in_green (req_tdata[31:24]),
      .in_blue  (req_tdata[39:32]),
      .in_alpha (req_tdata[47:40]),
      .cfg      (cfg),
      .push     (push),
      .job      (push_job)
   );

   pngunf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   pngunf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (not_empty),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_argb     (out_argb),
      .out_col      (out_col),
      .out_row_done (out_row_done),
      .out_last     (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, out_col, out_argb};
   assign rsp_tuser = out_row_done;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the PNG scanline unfilter to ARGB8888 block
// A predictor in the testbench rebuilds each row from its filter and unpacks
// the pixels. Directed tests come first, then random images with random
// idling on both streams. Every pixel transfer is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [31:0] argb;
      logic [11:0] col;
      logic        row_done;
      logic        run_end;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_data;

   png_scanline_unfilter_to_argb u_dut (.*);

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 5000;

   pixel_type   pixel_q[$];
   int          errors = 0;
   int          pixels_seen = 0;
   int          bytes_sent = 0;
   int          images_sent = 0;
   int          idle_cycles = 0;
   bit          steady = 0;

   // Predictor state
   logic [7:0]  line_mem [0:pngunf_pkg::ROW_STORE_BYTES-1];
   logic [31:0] pal_mem [0:pngunf_pkg::PALETTE_ENTRIES-1];
   int unsigned byte_pos;
   logic [2:0]  row_flt;
   bit          first_row;
   logic [7:0]  left_b [4];
   logic [7:0]  upleft_b [4];
   logic [23:0] part_pix;
   int unsigned col_cnt;
   logic [2:0]  m_ct;
   logic [3:0]  m_depth;
   logic [12:0] m_width;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (m_width == 0) return 1;
      if (m_width > pngunf_pkg::MAX_WIDTH) return pngunf_pkg::MAX_WIDTH;
      return m_width;
   endfunction

   function automatic int unsigned eff_depth();
      if (m_ct == pngunf_pkg::CT_RGB || m_ct == pngunf_pkg::CT_GA ||
          m_ct == pngunf_pkg::CT_RGBA) return 8;
      if (m_depth == 1 || m_depth == 2 || m_depth == 4) return m_depth;
      return 8;
   endfunction

   function automatic int unsigned chans();
      case (m_ct)
         pngunf_pkg::CT_RGB:  return 3;
         pngunf_pkg::CT_RGBA: return 4;
         pngunf_pkg::CT_GA:   return 2;
         default:             return 1;
      endcase
   endfunction

   function automatic int unsigned row_bytes();
      return (eff_width() * chans() * eff_depth() + 7) / 8;
   endfunction

   function automatic logic [7:0] paeth(input int a, input int b, input int c);
      int p, da, db, dc;
      p  = a + b - c;
      da = (p > a) ? p - a : a - p;
      db = (p > b) ? p - b : b - p;
      dc = (p > c) ? p - c : c - p;
      if (da <= db && da <= dc) return 8'(a);
      return (db <= dc) ? 8'(b) : 8'(c);
   endfunction

   function automatic void clear_row();
      for (int k = 0; k < 4; k++) begin
         left_b[k]   = 0;
         upleft_b[k] = 0;
      end
      part_pix = 0;
      col_cnt  = 0;
   endfunction

   function automatic void add_pixel(input logic [31:0] pix);
      pixel_type p;
      if (col_cnt >= eff_width()) return;
      p.argb     = pix;
      p.col      = col_cnt[11:0];
      p.row_done = (col_cnt == eff_width() - 1);
      p.run_end  = 0;
      pixel_q.push_back(p);
      col_cnt++;
   endfunction

   function automatic void predict_item(input logic [1:0] cmd, input logic [47:0] d);
      int unsigned depth, ch, bpp, idx, per, scale, qs;
      logic [7:0]  x, a, b, c, v;
      logic [31:0] pix;
      x = d[7:0];
      case (cmd)
         pngunf_pkg::CMD_START: begin
            byte_pos  = 0;
            first_row = 1;
            clear_row();
         end
         pngunf_pkg::CMD_PALETTE: pal_mem[d[15:8]] = {d[47:40], d[23:16], d[31:24], d[39:32]};
         pngunf_pkg::CMD_BYTE: begin
            if (byte_pos == 0) begin
               row_flt  = (x <= 4) ? x[2:0] : pngunf_pkg::FLT_NONE;
               byte_pos = 1;
               clear_row();
            end else begin
               qs    = pixel_q.size();
               depth = eff_depth();
               ch    = chans();
               bpp   = (depth == 8) ? ch : 1;
               idx   = byte_pos - 1;
               a     = left_b[bpp-1];
               c     = first_row ? 8'd0 : upleft_b[bpp-1];
               b     = first_row ? 8'd0 : line_mem[idx];
               case (row_flt)
                  pngunf_pkg::FLT_SUB:   x = x + a;
                  pngunf_pkg::FLT_UP:    x = x + b;
                  pngunf_pkg::FLT_AVG:   x = x + 8'((int'(a) + int'(b)) >> 1);
                  pngunf_pkg::FLT_PAETH: x = x + paeth(a, b, c);
                  default:   ;
               endcase
               line_mem[idx] = x;
               for (int k = 3; k > 0; k--) begin
                  left_b[k]   = left_b[k-1];
                  upleft_b[k] = upleft_b[k-1];
               end
               left_b[0]   = x;
               upleft_b[0] = b;
               if (depth == 8) begin
                  if (idx % ch + 1 < ch) begin
                     part_pix = {part_pix[15:0], x};
                  end else begin
                     case (m_ct)
                        pngunf_pkg::CT_RGB:  pix = {8'hFF, part_pix[15:0], x};
                        pngunf_pkg::CT_RGBA: pix = {x, part_pix};
                        pngunf_pkg::CT_GA:   pix = {x, part_pix[7:0], part_pix[7:0],
                                                    part_pix[7:0]};
                        pngunf_pkg::CT_PAL:  pix = pal_mem[x];
                        default:             pix = {8'hFF, x, x, x};
                     endcase
                     part_pix = 0;
                     add_pixel(pix);
                  end
               end else begin
                  per   = 8 / depth;
                  scale = (depth == 1) ? 255 : (depth == 2) ? 85 : 17;
                  for (int s = 0; s < per; s++) begin
                     v = 8'((x >> (8 - depth * (s + 1))) & ((1 << depth) - 1));
                     if (m_ct == pngunf_pkg::CT_PAL) pix = pal_mem[v];
                     else pix = {8'hFF, {3{8'(v * scale)}}};
                     add_pixel(pix);
                  end
               end
               if (pixel_q.size() > qs) pixel_q[pixel_q.size()-1].run_end = 1;
               if (idx + 1 >= row_bytes()) begin
                  byte_pos  = 0;
                  first_row = 0;
                  clear_row();
               end else begin
                  byte_pos++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Random idle gap on the input side before one item in four on average, none when steady.
   task automatic send_item(input logic [1:0] cmd, input logic [47:0] d);
      if (!steady && $urandom_range(3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      predict_item(cmd, d);
      if (cmd == pngunf_pkg::CMD_BYTE) bytes_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(pngunf_pkg::CMD_BYTE, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_FF00 | 48'(b));
   endtask

   task automatic send_row(input logic [7:0] flt);
      int unsigned n;
      n = row_bytes();
      send_byte(flt);
      repeat (n) send_byte(8'($urandom));
   endtask

   task automatic start_image();
      send_item(pngunf_pkg::CMD_START, 48'({$urandom, $urandom}));
      images_sent++;
   endtask

   task automatic load_palette(input logic [7:0] e, input logic [31:0] argb);
      send_item(pngunf_pkg::CMD_PALETTE,
                {argb[31:24], argb[7:0], argb[15:8], argb[23:16], e, 8'h00});
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [12:0] value);
      req_tvalid <= 0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (index)
         pngunf_pkg::CSR_COLOR_TYPE: m_ct    = value[2:0];
         pngunf_pkg::CSR_BIT_DEPTH:  m_depth = value[3:0];
         default:                    m_width = value;
      endcase
   endtask

   task automatic set_format(input logic [2:0] ct, input logic [3:0] depth,
                             input logic [12:0] width);
      write_reg(pngunf_pkg::CSR_COLOR_TYPE, 13'(ct));
      write_reg(pngunf_pkg::CSR_BIT_DEPTH, 13'(depth));
      write_reg(pngunf_pkg::CSR_IMAGE_WIDTH, width);
   endtask

   task automatic test_reset_format();
      start_image();
      send_row(8'(pngunf_pkg::FLT_NONE));
      send_row(8'(pngunf_pkg::FLT_SUB));
   endtask

   task automatic test_filters();
      set_format(pngunf_pkg::CT_RGB, 4'd1, 13'd3);
      start_image();
      for (int f = 0; f < 8; f++) send_row(8'(f));
      send_row(8'hFF);
      send_item(CMD_UNUSED, 48'hFFFF_FFFF_FFFF);
      send_byte(8'(pngunf_pkg::FLT_PAETH));
      send_byte(8'h00);
      start_image();
      send_row(8'(pngunf_pkg::FLT_UP));
      send_row(8'(pngunf_pkg::FLT_AVG));
   endtask

   task automatic test_low_depths();
      load_palette(8'h00, 32'h0000_0000);
      load_palette(8'hFF, 32'hFFFF_FFFF);
      for (int e = 1; e < 16; e++) load_palette(8'(e), $urandom);
      set_format(pngunf_pkg::CT_PAL, 4'd4, 13'd3);
      start_image();
      send_row(8'(pngunf_pkg::FLT_SUB));
      send_row(8'(pngunf_pkg::FLT_PAETH));
      set_format(pngunf_pkg::CT_GRAY, 4'd2, 13'd5);
      start_image();
      send_row(8'(pngunf_pkg::FLT_NONE));
      send_row(8'(pngunf_pkg::FLT_AVG));
      set_format(3'd7, 4'd1, 13'd0);
      start_image();
      send_row(8'(pngunf_pkg::FLT_UP));
      send_row(8'(pngunf_pkg::FLT_UP));
   endtask

   task automatic test_odd_formats();
      set_format(3'd5, 4'd1, 13'd20);
      start_image();
      send_row(8'(pngunf_pkg::FLT_PAETH));
      send_row(8'(pngunf_pkg::FLT_UP));
      set_format(pngunf_pkg::CT_PAL, 4'd8, 13'd4);
      start_image();
      send_row(8'(pngunf_pkg::FLT_SUB));
      set_format(pngunf_pkg::CT_GA, 4'd15, 13'd2);
      start_image();
      send_row(8'(pngunf_pkg::FLT_AVG));
      send_row(8'(pngunf_pkg::FLT_PAETH));
   endtask

   task automatic test_random_images();
      int unsigned budget, start_bytes, rows;
      logic [3:0] depths [5] = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd0};
      budget      = 70;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < budget) begin
         if (bytes_sent - start_bytes > budget * 2 / 3) steady = 1;
         depths[4] = 4'($urandom_range(15));
         set_format(3'($urandom_range(7)), depths[$urandom_range(4)],
                    13'(($urandom_range(9) == 0) ? $urandom_range(10, 1)
                                                 : $urandom_range(6, 1)));
         start_image();
         rows = $urandom_range(3, 1);
         for (int r = 0; r < rows; r++) begin
            if ($urandom_range(5) == 0) load_palette(8'($urandom), $urandom);
            if ($urandom_range(7) == 0) send_item(CMD_UNUSED, 48'({$urandom, $urandom}));
            if ($urandom_range(12) == 0) begin
               send_byte(8'($urandom_range(7)));
               send_byte(8'($urandom));
               start_image();
            end
            send_row(8'(($urandom_range(5) == 0) ? $urandom : $urandom_range(4)));
         end
      end
   endtask

   // Output side back-pressure in random bursts.
   initial begin
      rsp_tready <= 0;
      forever begin
         rsp_tready <= steady || $urandom_range(2) != 0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_seen++;
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected pixel, expected none, actual argb %h col %0d",
                     $time, rsp_tdata[31:0], rsp_tdata[43:32]);
            errors++;
         end else begin
            e = pixel_q.pop_front();
            if (rsp_tdata[31:0] !== e.argb) begin
               $display("%0t: argb expected %h actual %h", $time, e.argb, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[43:32] !== e.col) begin
               $display("%0t: column expected %0d actual %0d", $time, e.col, rsp_tdata[43:32]);
               errors++;
            end
            if (rsp_tuser[0] !== e.row_done) begin
               $display("%0t: row_done expected %b actual %b", $time, e.row_done, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tlast !== e.run_end) begin
               $display("%0t: tlast expected %b actual %b", $time, e.run_end, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired with %0d pixels outstanding", $time, pixel_q.size());
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset      <= 1;
      req_tvalid <= 0;
      req_tdata  <= 0;
      req_tuser  <= pngunf_pkg::CMD_START;
      csr_valid  <= 0;
      csr_index  <= pngunf_pkg::CSR_COLOR_TYPE;
      csr_data   <= 0;
      for (int k = 0; k < pngunf_pkg::PALETTE_ENTRIES; k++) begin
         pal_mem[k] = pngunf_pkg::OPAQUE_BLACK;
      end
      byte_pos  = 0;
      row_flt   = pngunf_pkg::FLT_NONE;
      first_row = 1;
      clear_row();
      m_ct    = pngunf_pkg::CT_RGBA;
      m_depth = 4'd8;
      m_width = 13'd1;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_format();
      test_filters();
      test_low_depths();
      test_odd_formats();
      test_random_images();
      req_tvalid <= 0;
      steady = 1;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d images, %0d scanline bytes and %0d pixels", images_sent,
               bytes_sent, pixels_seen);
      $display("across all colour types, bit depths, filters and a range of small widths.");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pngunf_pkg.sv
rtl/pngunf_front.sv
rtl/pngunf_queue.sv
rtl/pngunf_back.sv
rtl/png_scanline_unfilter_to_argb.sv
verif/testbench.sv
